>>> rtl/core/fwil_pkg.sv
// ----------------------------------------------------------------------------
// fwil_pkg - firmware image layout parser package
// Status codes, check mode codes, layout constants and the aux length table.
// ----------------------------------------------------------------------------
package fwil_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ARG   = 2'd1,
    ST_TOO_SMALL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CM_CRC      = 3'd0,
    CM_SHA      = 3'd1,
    CM_GCM      = 3'd2,
    CM_CBC      = 3'd3,
    CM_CBC_HMAC = 3'd4
  } check_mode_t;

  localparam int unsigned CRC_SIZE   = 4;
  localparam int unsigned META_BYTES = 4;
  localparam int unsigned MIN_IMAGE  = CRC_SIZE + META_BYTES;
  localparam int unsigned MODE_MAX   = 4;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 208;

  // auxiliary bytes per check mode
  function automatic logic [5:0] aux_len_f(input logic [2:0] mode);
    logic [5:0] len;
    unique case (mode)
      CM_CRC:      len = 6'd0;
      CM_SHA:      len = 6'd32;
      CM_GCM:      len = 6'd28;
      CM_CBC:      len = 6'd16;
      CM_CBC_HMAC: len = 6'd48;
      default:     len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/core/firmware_image_layout_parser.sv
// ----------------------------------------------------------------------------
// firmware_image_layout_parser - image tail metadata check and layout offsets
// Checks size, magic and mode, then reports payload length and section offsets.
// ----------------------------------------------------------------------------
// input transactions pass through three register stages (s1, s2, s3) to out_tvalid
// throughput: one transaction per cycle; each stage advances when the next has room
// the third stage is the output register, so input keeps flowing while a result waits until stages 1 and 2 fill
// reset: rst_n low clears all stage valid bits and expected_magic to zero
module firmware_image_layout_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [7:0]                           cfg_wr_data,  // expected_magic
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // image_size[31:0], meta_magic[39:32], meta_mode_byte[47:40],
  // meta_version_len[55:48], meta_tag_len[63:56]
  input  logic [fwil_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // status[1:0], check_mode[4:2], header_first[5], aux_length[11:6],
  // payload_length[43:12], payload_offset[75:44], aux_offset[107:76],
  // version_offset[139:108], tag_offset[171:140], crc_offset[203:172], zero pad
  output logic [fwil_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import fwil_pkg::*;

  logic [7:0] magic_r;

  logic en1, en2, en3;

  // stage 1: checks and small sums
  logic        s1_v_r;
  logic [31:0] s1_size_r;
  logic        s1_bad_r;
  logic [2:0]  s1_mode_r;
  logic        s1_front_r;
  logic [5:0]  s1_alen_r;
  logic [9:0]  s1_ovh_r;
  logic [8:0]  s1_av_r;
  logic [9:0]  s1_avt_r;
  logic [8:0]  s1_toff_r;
  logic [9:0]  s1_aoff_r;
  logic [9:0]  s1_poff_r;

  // stage 2: overhead compare and payload length
  logic        s2_v_r;
  status_t     s2_status_r;
  logic [31:0] s2_plen_r;
  logic [2:0]  s2_mode_r;
  logic        s2_front_r;
  logic [5:0]  s2_alen_r;
  logic [8:0]  s2_av_r;
  logic [9:0]  s2_avt_r;
  logic [8:0]  s2_toff_r;
  logic [9:0]  s2_aoff_r;
  logic [9:0]  s2_poff_r;

  // stage 3: output register
  logic        s3_v_r;
  status_t     s3_status_r;
  logic [2:0]  s3_mode_r;
  logic        s3_front_r;
  logic [5:0]  s3_alen_r;
  logic [31:0] s3_plen_r;
  logic [31:0] s3_poff_r;
  logic [31:0] s3_aoff_r;
  logic [31:0] s3_voff_r;
  logic [31:0] s3_toff_r;
  logic [31:0] s3_coff_r;

  // stage 1 combinational
  logic [31:0] in_size;
  logic [7:0]  in_magic;
  logic [6:0]  in_mode7;
  logic [7:0]  in_vlen;
  logic [7:0]  in_tlen;
  logic [5:0]  s1_alen_nxt;
  logic [8:0]  s1_vt;
  logic [9:0]  s1_avt_nxt;

  // stage 2 combinational
  logic [32:0] s2_diff;
  status_t     s2_status_nxt;

  // stage 3 combinational
  logic [31:0] s3_voff_trl;
  logic [31:0] s3_toff_trl;
  logic [31:0] s3_coff_trl;
  logic        s3_ok;

  assign en3       = !s3_v_r || out_tready;
  assign en2       = !s2_v_r || en3;
  assign en1       = !s1_v_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= 8'd0;
    end else if (cfg_wr_en) begin
      magic_r <= cfg_wr_data;
    end
  end

  assign in_size  = in_tdata[31:0];
  assign in_magic = in_tdata[39:32];
  assign in_mode7 = in_tdata[46:40];
  assign in_vlen  = in_tdata[55:48];
  assign in_tlen  = in_tdata[63:56];

  assign s1_alen_nxt = aux_len_f(in_mode7[2:0]);
  assign s1_vt       = {1'b0, in_vlen} + {1'b0, in_tlen};
  assign s1_avt_nxt  = {4'b0, s1_alen_nxt} + {1'b0, s1_vt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_size_r  <= in_size;
      s1_bad_r   <= (in_size < 32'(MIN_IMAGE)) || (in_magic != magic_r) ||
                    (in_mode7 > 7'(MODE_MAX));
      s1_mode_r  <= in_mode7[2:0];
      s1_front_r <= in_tdata[47];
      s1_alen_r  <= s1_alen_nxt;
      s1_ovh_r   <= 10'(MIN_IMAGE) + s1_avt_nxt;
      s1_av_r    <= {3'b0, s1_alen_nxt} + {1'b0, in_vlen};
      s1_avt_r   <= s1_avt_nxt;
      s1_toff_r  <= 9'(CRC_SIZE) + {1'b0, in_vlen};
      s1_aoff_r  <= 10'(CRC_SIZE) + {1'b0, s1_vt};
      s1_poff_r  <= 10'(CRC_SIZE) + s1_avt_nxt;
    end
  end

  // borrow out of the subtract means the image does not cover the overhead
  assign s2_diff = {1'b0, s1_size_r} - {23'b0, s1_ovh_r};

  always_comb begin
    priority if (s1_bad_r) begin
      s2_status_nxt = ST_BAD_ARG;
    end else if (s2_diff[32]) begin
      s2_status_nxt = ST_TOO_SMALL;
    end else begin
      s2_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_status_r <= s2_status_nxt;
      s2_plen_r   <= s2_diff[31:0];
      s2_mode_r   <= s1_mode_r;
      s2_front_r  <= s1_front_r;
      s2_alen_r   <= s1_alen_r;
      s2_av_r     <= s1_av_r;
      s2_avt_r    <= s1_avt_r;
      s2_toff_r   <= s1_toff_r;
      s2_aoff_r   <= s1_aoff_r;
      s2_poff_r   <= s1_poff_r;
    end
  end

  // trailer layout: payload | aux | version | tag | crc | meta
  assign s3_voff_trl = s2_plen_r + {26'b0, s2_alen_r};
  assign s3_toff_trl = s2_plen_r + {23'b0, s2_av_r};
  assign s3_coff_trl = s2_plen_r + {22'b0, s2_avt_r};
  assign s3_ok       = (s2_status_r == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_status_r <= s2_status_r;
      s3_mode_r   <= s3_ok ? s2_mode_r : 3'd0;
      s3_front_r  <= s3_ok && s2_front_r;
      s3_alen_r   <= s3_ok ? s2_alen_r : 6'd0;
      s3_plen_r   <= s3_ok ? s2_plen_r : 32'd0;
      if (!s3_ok) begin
        s3_poff_r <= 32'd0;
        s3_aoff_r <= 32'd0;
        s3_voff_r <= 32'd0;
        s3_toff_r <= 32'd0;
        s3_coff_r <= 32'd0;
      end else if (s2_front_r) begin
        // header first: crc | version | tag | aux | payload | meta
        s3_poff_r <= {22'b0, s2_poff_r};
        s3_aoff_r <= {22'b0, s2_aoff_r};
        s3_voff_r <= 32'(CRC_SIZE);
        s3_toff_r <= {23'b0, s2_toff_r};
        s3_coff_r <= 32'd0;
      end else begin
        s3_poff_r <= 32'd0;
        s3_aoff_r <= s2_plen_r;
        s3_voff_r <= s3_voff_trl;
        s3_toff_r <= s3_toff_trl;
        s3_coff_r <= s3_coff_trl;
      end
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = {4'b0, s3_coff_r, s3_toff_r, s3_voff_r, s3_aoff_r, s3_poff_r,
                       s3_plen_r, s3_alen_r, s3_front_r, s3_mode_r, s3_status_r};

  // error results carry nothing but the status
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_status_r != ST_OK) |->
      (s3_mode_r == 3'd0 && !s3_front_r && s3_alen_r == 6'd0 && s3_plen_r == 32'd0 &&
       s3_poff_r == 32'd0 && s3_coff_r == 32'd0 && s3_voff_r == 32'd0))
    else $error("error result has nonzero layout fields");

  a_hdr_layout: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_status_r == ST_OK && s3_front_r) |->
      (s3_coff_r == 32'd0 && s3_voff_r == 32'(CRC_SIZE) &&
       s3_poff_r == s3_aoff_r + {26'b0, s3_alen_r}))
    else $error("header-first offsets inconsistent");

  a_trl_layout: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s3_status_r == ST_OK && !s3_front_r) |->
      (s3_poff_r == 32'd0 && s3_aoff_r == s3_plen_r &&
       s3_voff_r == s3_plen_r + {26'b0, s3_alen_r}))
    else $error("trailer offsets inconsistent");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && s2_v_r && s3_v_r && !out_tready))
    else $error("input stalled while pipeline has room");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !out_tready) |=> (s3_v_r && $stable(s3_plen_r) && $stable(s3_status_r)))
    else $error("stalled result changed");

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench - firmware image layout parser
// Directed table then three random phases with different magic values and
// handshake pressure; every result is checked against a typed expectation or a built-in predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fwil_pkg::*;

  localparam int ITEMS_PER_PHASE = 476;
  localparam int HOLD_CYCLES     = 300;
  localparam int LAYOUT_W        = 204;
  localparam longint TIMEOUT_NS  = 2_000_000;

  // one image description, last field in the lowest bits
  typedef struct packed {
    logic [7:0]  tag_len;
    logic [7:0]  ver_len;
    logic [7:0]  mode_byte;
    logic [7:0]  magic;
    logic [31:0] image_size;
  } image_item_t;

  // one layout result, last field in the lowest bits
  typedef struct packed {
    logic [31:0] crc_offset;
    logic [31:0] tag_offset;
    logic [31:0] version_offset;
    logic [31:0] aux_offset;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [5:0]  aux_length;
    logic        header_first;
    check_mode_t check_mode;
    status_t     status;
  } layout_t;

  typedef struct packed {
    image_item_t item;
    logic        typed;
    layout_t     want;
  } table_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [7:0]             cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  layout_t    layouts_due[$];
  table_row_t stim_table[$];
  logic [7:0] magic_ref;
  int         send_idle_pct;
  int         recv_idle_pct;
  logic       hold_req;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  int         items_sent;
  int         result_count;
  int         error_count;
  int         ok_count;
  int         bad_arg_count;
  int         too_small_count;
  int         magic_writes;

  firmware_image_layout_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] aux_bytes_for(input logic [6:0] mode);
    logic [31:0] n;
    case (mode)
      7'd1:    n = 32'd32;
      7'd2:    n = 32'd28;
      7'd3:    n = 32'd16;
      7'd4:    n = 32'd48;
      default: n = 32'd0;
    endcase
    return n;
  endfunction

  function automatic layout_t predict_layout(input image_item_t it, input logic [7:0] magic);
    layout_t     r;
    logic [6:0]  mode;
    logic [31:0] vlen;
    logic [31:0] tlen;
    logic [31:0] alen;
    logic [31:0] overhead;
    logic [31:0] plen;
    r    = '0;
    mode = it.mode_byte[6:0];
    if (it.image_size < MIN_IMAGE || it.magic != magic || mode > MODE_MAX) begin
      r.status = ST_BAD_ARG;
      return r;
    end
    vlen     = {24'd0, it.ver_len};
    tlen     = {24'd0, it.tag_len};
    alen     = aux_bytes_for(mode);
    overhead = CRC_SIZE + META_BYTES + vlen + tlen + alen;
    if (it.image_size < overhead) begin
      r.status = ST_TOO_SMALL;
      return r;
    end
    plen             = it.image_size - overhead;
    r.status         = ST_OK;
    r.check_mode     = check_mode_t'(mode[2:0]);
    r.header_first   = it.mode_byte[7];
    r.aux_length     = alen[5:0];
    r.payload_length = plen;
    if (it.mode_byte[7]) begin
      // crc | version | tag | aux | payload | meta
      r.crc_offset     = 32'd0;
      r.version_offset = CRC_SIZE;
      r.tag_offset     = CRC_SIZE + vlen;
      r.aux_offset     = CRC_SIZE + vlen + tlen;
      r.payload_offset = CRC_SIZE + vlen + tlen + alen;
    end else begin
      // payload | aux | version | tag | crc | meta
      r.payload_offset = 32'd0;
      r.aux_offset     = plen;
      r.version_offset = plen + alen;
      r.tag_offset     = plen + alen + vlen;
      r.crc_offset     = plen + alen + vlen + tlen;
    end
    return r;
  endfunction

  function automatic image_item_t mk(input logic [31:0] size, input logic [7:0] magic,
                                     input logic [7:0] mode_byte, input logic [7:0] vlen,
                                     input logic [7:0] tlen);
    image_item_t it;
    it.image_size  = size;
    it.magic       = magic;
    it.mode_byte   = mode_byte;
    it.ver_len     = vlen;
    it.tag_len     = tlen;
    return it;
  endfunction

  function automatic layout_t error_result(input status_t st);
    layout_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  // crc-mode success with no aux data
  function automatic layout_t crc_mode_result(input logic hf, input logic [31:0] plen,
                                              input logic [31:0] pay, input logic [31:0] ver,
                                              input logic [31:0] tag, input logic [31:0] crc);
    layout_t r;
    r                = '0;
    r.status         = ST_OK;
    r.check_mode     = CM_CRC;
    r.header_first   = hf;
    r.payload_length = plen;
    r.payload_offset = pay;
    r.aux_offset     = pay == 32'd0 ? plen : pay;
    r.version_offset = ver;
    r.tag_offset     = tag;
    r.crc_offset     = crc;
    return r;
  endfunction

  function automatic string layout_text(input layout_t l);
    return $sformatf("st=%0d mode=%0d hf=%0d aux=%0d plen=%h pay=%h aux@%h ver=%h tag=%h crc=%h",
                     l.status, l.check_mode, l.header_first, l.aux_length, l.payload_length,
                     l.payload_offset, l.aux_offset, l.version_offset, l.tag_offset,
                     l.crc_offset);
  endfunction

  function automatic logic [7:0] pick_len();
    int k;
    k = $urandom_range(99);
    if (k < 6) return 8'd0;
    if (k < 12) return 8'd255;
    if (k < 60) return 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  function automatic image_item_t random_image(input logic [7:0] magic);
    image_item_t it;
    logic [6:0]  mode;
    logic [31:0] ovh;
    int          k;
    it.magic = ($urandom_range(99) < 88) ? magic : 8'($urandom_range(255));
    k = $urandom_range(99);
    if (k < 80) mode = 7'($urandom_range(4));
    else if (k < 90) mode = 7'($urandom_range(127, 5));
    else mode = 7'($urandom_range(127));
    it.mode_byte   = {1'($urandom_range(1)), mode};
    it.ver_len     = pick_len();
    it.tag_len     = pick_len();
    ovh = CRC_SIZE + META_BYTES + it.ver_len + it.tag_len + aux_bytes_for(mode);
    k = $urandom_range(99);
    if (k < 45) it.image_size = ovh + $urandom_range(300);
    else if (k < 58) it.image_size = ovh - $urandom_range(8, 1);
    else if (k < 64) it.image_size = ovh;
    else if (k < 72) it.image_size = $urandom_range(15);
    else if (k < 90) it.image_size = $urandom();
    else it.image_size = 32'hFFFF_FFFF - $urandom_range(255);
    return it;
  endfunction

  task automatic add_row(input image_item_t it, input logic typed, input layout_t want);
    table_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input image_item_t it, input layout_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    layouts_due.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_magic(input logic [7:0] value);
    while (layouts_due.size() != 0) @(posedge clk);
    repeat (5) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    magic_ref    = value;
    magic_writes++;
  endtask

  task automatic report_failure(input string what, input layout_t want, input layout_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected %s", layout_text(want));
      $display("  actual   %s", layout_text(got));
    end
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req !== hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    layout_t got;
    layout_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = layout_t'(out_tdata[LAYOUT_W-1:0]);
      result_count++;
      case (got.status)
        ST_OK:        ok_count++;
        ST_BAD_ARG:   bad_arg_count++;
        ST_TOO_SMALL: too_small_count++;
        default:      ;
      endcase
      if (layouts_due.size() == 0) begin
        report_failure("result transaction with nothing outstanding", '0, got);
      end else begin
        want = layouts_due.pop_front();
        if (got.status !== want.status || got.check_mode !== want.check_mode ||
            got.header_first !== want.header_first || got.aux_length !== want.aux_length ||
            got.payload_length !== want.payload_length ||
            got.payload_offset !== want.payload_offset ||
            got.aux_offset !== want.aux_offset ||
            got.version_offset !== want.version_offset ||
            got.tag_offset !== want.tag_offset || got.crc_offset !== want.crc_offset ||
            out_tdata[OUT_TDATA_W-1:LAYOUT_W] !== '0) begin
          report_failure("layout mismatch", want, got);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL firmware_image_layout_parser");
    $finish;
  end

  initial begin
    layout_t want;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 8'd0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    hold_req        = 1'b0;
    magic_ref       = 8'd0;
    send_idle_pct   = 33;
    recv_idle_pct   = 56;
    items_sent      = 0;
    result_count    = 0;
    error_count     = 0;
    ok_count        = 0;
    bad_arg_count   = 0;
    too_small_count = 0;
    magic_writes    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, magic still at its reset value of zero
    add_row(mk(32'd0, 8'h00, 8'h00, 8'd0, 8'd0), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'd7, 8'h00, 8'h00, 8'd0, 8'd0), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'd8, 8'h00, 8'h00, 8'd0, 8'd0), 1'b1,
            crc_mode_result(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    add_row(mk(32'd8, 8'h00, 8'h80, 8'd0, 8'd0), 1'b1,
            crc_mode_result(1'b1, 32'd0, 32'd4, 32'd4, 32'd4, 32'd0));
    add_row(mk(32'd100, 8'h01, 8'h00, 8'd0, 8'd0), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'hFFFF_FFFF, 8'hFF, 8'h00, 8'd0, 8'd0), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'd100, 8'h00, 8'h05, 8'd0, 8'd0), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'd100, 8'h00, 8'h7F, 8'd0, 8'd0), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'd100, 8'h00, 8'hFF, 8'd255, 8'd255), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'd100, 8'h00, 8'h85, 8'd0, 8'd0), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'd7, 8'hAA, 8'h55, 8'd0, 8'd0), 1'b1, error_result(ST_BAD_ARG));
    add_row(mk(32'd1000, 8'h00, 8'h01, 8'd3, 8'd5), 1'b0, '0);
    add_row(mk(32'd1000, 8'h00, 8'h82, 8'd3, 8'd5), 1'b0, '0);
    add_row(mk(32'd1000, 8'h00, 8'h03, 8'd17, 8'd9), 1'b0, '0);
    add_row(mk(32'd1000, 8'h00, 8'h84, 8'd1, 8'd2), 1'b0, '0);
    add_row(mk(32'd1000, 8'h00, 8'h04, 8'd1, 8'd2), 1'b0, '0);
    add_row(mk(32'd565, 8'h00, 8'h04, 8'd255, 8'd255), 1'b1, error_result(ST_TOO_SMALL));
    add_row(mk(32'd566, 8'h00, 8'h84, 8'd255, 8'd255), 1'b0, '0);
    add_row(mk(32'd566, 8'h00, 8'h04, 8'd255, 8'd255), 1'b0, '0);
    add_row(mk(32'd39, 8'h00, 8'h01, 8'd0, 8'd0), 1'b1, error_result(ST_TOO_SMALL));
    add_row(mk(32'd39, 8'h00, 8'h02, 8'd1, 8'd2), 1'b0, '0);
    add_row(mk(32'hFFFF_FFFF, 8'h00, 8'h84, 8'd255, 8'd255), 1'b0, '0);
    add_row(mk(32'hFFFF_FFFF, 8'h00, 8'h04, 8'd255, 8'd255), 1'b0, '0);
    add_row(mk(32'h8000_0000, 8'h00, 8'h83, 8'h55, 8'hAA), 1'b0, '0);
    foreach (stim_table[i]) begin
      want = stim_table[i].typed ? stim_table[i].want
                                 : predict_layout(stim_table[i].item, magic_ref);
      send_item(stim_table[i].item, want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      in_tvalid <= 1'b0;
      case (phase)
        0: write_magic(8'hFF);
        1: write_magic(8'($urandom_range(254, 1)));
        default: write_magic(8'h00);
      endcase
      send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 56 : 0;
      recv_idle_pct <= (phase == 0) ? 56 : (phase == 1) ? 33 : 0;
      // long output stall while the sender keeps pushing
      if (phase == 1) hold_req <= ~hold_req;
      repeat (ITEMS_PER_PHASE) begin
        image_item_t it;
        it = random_image(magic_ref);
        send_item(it, predict_layout(it, magic_ref));
      end
    end
    in_tvalid <= 1'b0;

    while (layouts_due.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d image descriptions over %0d magic settings plus reset value",
             items_sent, magic_writes);
    $display("results: %0d ok, %0d bad argument, %0d short of overhead, %0d mismatches",
             ok_count, bad_arg_count, too_small_count, error_count);
    if (error_count == 0 && layouts_due.size() == 0) begin
      $display("PASS firmware_image_layout_parser");
    end else begin
      $display("FAIL firmware_image_layout_parser");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fwil_pkg.sv
rtl/core/firmware_image_layout_parser.sv
verif/testbench.sv
